// ===== hdl/event_word_deframer_core_assert.svh =====
// Assertion macros shared by the deframer modules.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef EVENT_WORD_DEFRAMER_CORE_ASSERT_SVH
`define EVENT_WORD_DEFRAMER_CORE_ASSERT_SVH

// The consequence must hold in the same cycle as the antecedent.
`define EWD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequence must hold in the cycle after the antecedent.
`define EWD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/ewd_pkg.sv =====
// Package of the event word deframer: sizes, codes, command and record types.
// Used by every module of the block; depends on nothing.
package ewd_pkg;

    localparam int EVENT_COUNT_BITS = 16;
    localparam int CHUNK_BITS       = 16;
    localparam int FILE_BITS        = 41;
    localparam int MAX_BYTES_BITS   = 40;
    localparam int TYPE_BITS        = 16;

    localparam logic [31:0] SEPARATOR_WORD = 32'haaaaaaaa;
    localparam int MIN_EVENT_BYTES  = 56;
    localparam int LEN_TOLERANCE    = 8;
    localparam int RECORD_OVERHEAD  = 16;
    localparam int HEADER_WORDS     = 3;

    localparam logic [EVENT_COUNT_BITS-1:0] EVT_MAX = '1;
    localparam logic [FILE_BITS-1:0]        FILE_MAX = '1;

    localparam int CMD_DEPTH = 4;
    localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
    localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);
    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_SHORT    = 2'd1;
    localparam logic [1:0] STAT_MISMATCH = 2'd2;

    localparam logic KIND_EVENT = 1'b0;
    localparam logic KIND_ROLL  = 1'b1;

    localparam logic REG_RECORD_TYPE = 1'b0;
    localparam logic REG_MAX_FILE    = 1'b1;

    typedef struct packed {
        logic                        has_event;
        logic                        buf_end;
        logic [1:0]                  status;
        logic [11:0]                 board;
        logic [47:0]                 stamp;
        logic [EVENT_COUNT_BITS-1:0] evt_bytes;
        logic [12:0]                 decl;
    } cmd_t;

    typedef struct packed {
        logic        kind;
        logic [1:0]  status;
        logic [11:0] board;
        logic [47:0] stamp;
        logic [15:0] evt_len;
        logic [12:0] decl;
        logic [15:0] chunk;
        logic        last;
    } rec_t;

    function automatic logic [31:0] swap32(input logic [31:0] w);
        return {w[7:0], w[15:8], w[23:16], w[31:24]};
    endfunction

endpackage

// ===== hdl/ewd_cmd_queue.sv =====
// Short queue of classified commands between the front and the back part.
// Depends on ewd_pkg for the command type and depth.
`include "event_word_deframer_core_assert.svh"

module ewd_cmd_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  ewd_pkg::cmd_t wr_data,
    output logic          full,
    input  logic          rd_en,
    output logic          empty,
    output ewd_pkg::cmd_t head
);

    ewd_pkg::cmd_t                   mem_reg [ewd_pkg::CMD_DEPTH];
    logic [ewd_pkg::CMD_PTR_W-1:0]   wptr_reg;
    logic [ewd_pkg::CMD_PTR_W-1:0]   wptr_next;
    logic [ewd_pkg::CMD_PTR_W-1:0]   rptr_reg;
    logic [ewd_pkg::CMD_PTR_W-1:0]   rptr_next;
    logic [ewd_pkg::CMD_CNT_W-1:0]   cnt_reg;
    logic [ewd_pkg::CMD_CNT_W-1:0]   cnt_next;
    logic                            do_wr;
    logic                            do_rd;

    assign full  = (cnt_reg == ewd_pkg::CMD_CNT_W'(ewd_pkg::CMD_DEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = mem_reg[rptr_reg];
    assign do_wr = wr_en && !full;
    assign do_rd = rd_en && !empty;

    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (do_wr)
        begin
            wptr_next = (wptr_reg == ewd_pkg::CMD_PTR_W'(ewd_pkg::CMD_DEPTH - 1)) ?
                        '0 : wptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rptr_next = (rptr_reg == ewd_pkg::CMD_PTR_W'(ewd_pkg::CMD_DEPTH - 1)) ?
                        '0 : rptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wptr_reg] <= wr_data;
        end
    end

    `EWD_ASSERT_SAME(a_cmd_cnt_bound, 1'b1, cnt_reg <= ewd_pkg::CMD_CNT_W'(ewd_pkg::CMD_DEPTH), "command queue count beyond its depth")

endmodule

// ===== hdl/ewd_front.sv =====
// Front part: takes words, keeps the header words and the event byte count,
// and classifies each closed event into a command. Depends on ewd_pkg.
`include "event_word_deframer_core_assert.svh"

module ewd_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  logic [31:0]   data_word,
    input  logic          buffer_end,
    output logic          cmd_push,
    output ewd_pkg::cmd_t cmd_data
);

    localparam int ECB = ewd_pkg::EVENT_COUNT_BITS;

    logic [31:0]    hdr_reg [ewd_pkg::HEADER_WORDS];
    logic [31:0]    hdr_cur [ewd_pkg::HEADER_WORDS];
    logic [ECB-1:0] cnt_reg;
    logic [ECB-1:0] cnt_next;
    logic [ECB-1:0] cnt_inc;
    logic           is_sep;
    logic           hdr_wr;
    logic [1:0]     slot;
    logic           close;
    logic [31:0]    h0s;
    logic [31:0]    h1s;
    logic [31:0]    h2s;
    logic [12:0]    decl;
    logic [ECB:0]   n_w;
    logic [ECB:0]   d_w;
    logic           short_evt;
    logic           mismatch;

    assign is_sep  = (data_word == ewd_pkg::SEPARATOR_WORD);
    assign slot    = cnt_reg[3:2];
    assign hdr_wr  = accept && !is_sep && (cnt_reg < ECB'(4 * ewd_pkg::HEADER_WORDS));
    assign cnt_inc = (is_sep) ? cnt_reg :
                     (cnt_reg > ewd_pkg::EVT_MAX - ECB'(4)) ? ewd_pkg::EVT_MAX :
                     cnt_reg + ECB'(4);
    assign close   = (is_sep || buffer_end) && (cnt_inc != '0);

    always_comb
    begin
        for (int i = 0; i < ewd_pkg::HEADER_WORDS; i++)
        begin
            hdr_cur[i] = (hdr_wr && (slot == 2'(i))) ? data_word : hdr_reg[i];
        end
    end

    assign h0s  = ewd_pkg::swap32(hdr_cur[0]);
    assign h1s  = ewd_pkg::swap32(hdr_cur[1]);
    assign h2s  = ewd_pkg::swap32(hdr_cur[2]);
    assign decl = {h0s[26:16], 2'b00};
    assign n_w  = {1'b0, cnt_inc};
    assign d_w  = (ECB + 1)'(decl);

    assign short_evt = (cnt_inc < ECB'(ewd_pkg::MIN_EVENT_BYTES));
    assign mismatch  = (n_w > d_w + (ECB + 1)'(ewd_pkg::LEN_TOLERANCE)) ||
                       (d_w > n_w + (ECB + 1)'(ewd_pkg::LEN_TOLERANCE));

    always_comb
    begin
        cmd_data.has_event = close;
        cmd_data.buf_end   = buffer_end;
        cmd_data.status    = short_evt ? ewd_pkg::STAT_SHORT :
                             mismatch  ? ewd_pkg::STAT_MISMATCH : ewd_pkg::STAT_OK;
        cmd_data.board     = h0s[15:4];
        cmd_data.stamp     = {h2s[15:0], h1s};
        cmd_data.evt_bytes = cnt_inc;
        cmd_data.decl      = decl;
    end

    assign cmd_push = accept && (close || buffer_end);
    assign cnt_next = close ? '0 : cnt_inc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (accept)
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hdr_wr)
        begin
            hdr_reg[slot] <= data_word;
        end
    end

    `EWD_ASSERT_NEXT(a_close_clears_count, accept && close, cnt_reg == '0, "event byte count not cleared after an event closed")

endmodule

// ===== hdl/ewd_back.sv =====
// Back part: carries out commands, keeps the file byte count and chunk index,
// and holds finished records in an output queue. Depends on ewd_pkg.
`include "event_word_deframer_core_assert.svh"

module ewd_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ewd_pkg::cmd_t                       cmd_head,
    input  logic                                cmd_empty,
    output logic                                cmd_pop,
    input  logic [ewd_pkg::MAX_BYTES_BITS-1:0]  max_file_bytes,
    input  logic                                pop,
    output logic                                empty,
    output ewd_pkg::rec_t                       rec
);

    typedef enum logic [1:0] {
        BK_RUN  = 2'b01,
        BK_ROLL = 2'b10
    } bk_state_t;

    localparam int FB = ewd_pkg::FILE_BITS;

    bk_state_t                       state_reg;
    bk_state_t                       state_next;
    logic [FB-1:0]                   file_reg;
    logic [FB-1:0]                   file_next;
    logic [ewd_pkg::CHUNK_BITS-1:0]  chunk_reg;
    logic [ewd_pkg::CHUNK_BITS-1:0]  chunk_next;
    logic [ewd_pkg::CHUNK_BITS-1:0]  chunk_inc;
    logic [FB:0]                     sum;
    logic [FB-1:0]                   file_add;
    logic                            roll;
    logic                            go;
    logic                            wr_en;
    ewd_pkg::rec_t                   wr_rec;

    ewd_pkg::rec_t                   out_reg [ewd_pkg::OUT_DEPTH];
    logic [ewd_pkg::OUT_PTR_W-1:0]   owptr_reg;
    logic [ewd_pkg::OUT_PTR_W-1:0]   orptr_reg;
    logic [ewd_pkg::OUT_CNT_W-1:0]   ocnt_reg;
    logic [ewd_pkg::OUT_CNT_W-1:0]   ocnt_next;
    logic                            room;
    logic                            out_rd;

    assign room   = (ocnt_reg != ewd_pkg::OUT_CNT_W'(ewd_pkg::OUT_DEPTH));
    assign empty  = (ocnt_reg == '0);
    assign rec    = out_reg[orptr_reg];
    assign out_rd = pop && !empty;
    assign go     = !cmd_empty && room;

    assign sum       = {1'b0, file_reg} + (FB + 1)'(cmd_head.evt_bytes)
                       + (FB + 1)'(ewd_pkg::RECORD_OVERHEAD);
    assign file_add  = (cmd_head.has_event && (cmd_head.status == ewd_pkg::STAT_OK)) ?
                       (sum[FB] ? ewd_pkg::FILE_MAX : sum[FB-1:0]) : file_reg;
    assign roll      = cmd_head.buf_end && (file_add >= FB'(max_file_bytes));
    assign chunk_inc = chunk_reg + 1'b1;

    always_comb
    begin
        state_next = state_reg;
        file_next  = file_reg;
        chunk_next = chunk_reg;
        cmd_pop    = 1'b0;
        wr_en      = 1'b0;
        wr_rec     = '0;
        wr_rec.last = 1'b1;
        case (state_reg)
            BK_RUN:
            begin
                if (go)
                begin
                    if (cmd_head.has_event)
                    begin
                        wr_en          = 1'b1;
                        wr_rec.kind    = ewd_pkg::KIND_EVENT;
                        wr_rec.status  = cmd_head.status;
                        wr_rec.board   = cmd_head.board;
                        wr_rec.stamp   = cmd_head.stamp;
                        wr_rec.evt_len = 16'(cmd_head.evt_bytes);
                        wr_rec.decl    = cmd_head.decl;
                        wr_rec.chunk   = 16'(chunk_reg);
                        wr_rec.last    = !roll;
                        if (roll)
                        begin
                            file_next  = '0;
                            chunk_next = chunk_inc;
                            state_next = BK_ROLL;
                        end
                        else
                        begin
                            file_next = file_add;
                            cmd_pop   = 1'b1;
                        end
                    end
                    else
                    begin
                        cmd_pop = 1'b1;
                        if (roll)
                        begin
                            wr_en        = 1'b1;
                            wr_rec.kind  = ewd_pkg::KIND_ROLL;
                            wr_rec.chunk = 16'(chunk_inc);
                            file_next    = '0;
                            chunk_next   = chunk_inc;
                        end
                    end
                end
            end
            BK_ROLL:
            begin
                if (go)
                begin
                    wr_en        = 1'b1;
                    wr_rec.kind  = ewd_pkg::KIND_ROLL;
                    wr_rec.chunk = 16'(chunk_reg);
                    cmd_pop      = 1'b1;
                    state_next   = BK_RUN;
                end
            end
            default:
            begin
                state_next = BK_RUN;
            end
        endcase
    end

    always_comb
    begin
        ocnt_next = ocnt_reg;
        if (wr_en && !out_rd)
        begin
            ocnt_next = ocnt_reg + 1'b1;
        end
        else if (out_rd && !wr_en)
        begin
            ocnt_next = ocnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_RUN;
            file_reg  <= '0;
            chunk_reg <= '0;
            owptr_reg <= '0;
            orptr_reg <= '0;
            ocnt_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            file_reg  <= file_next;
            chunk_reg <= chunk_next;
            ocnt_reg  <= ocnt_next;
            if (wr_en)
            begin
                owptr_reg <= (owptr_reg == ewd_pkg::OUT_PTR_W'(ewd_pkg::OUT_DEPTH - 1)) ?
                             '0 : owptr_reg + 1'b1;
            end
            if (out_rd)
            begin
                orptr_reg <= (orptr_reg == ewd_pkg::OUT_PTR_W'(ewd_pkg::OUT_DEPTH - 1)) ?
                             '0 : orptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            out_reg[owptr_reg] <= wr_rec;
        end
    end

    `EWD_ASSERT_SAME(a_roll_has_cmd, state_reg == BK_ROLL, !cmd_empty, "pending rollover without its command")
    `EWD_ASSERT_NEXT(a_roll_clears_file, wr_en && (wr_rec.kind == ewd_pkg::KIND_ROLL), file_reg == '0, "file byte count not cleared by rollover")
    `EWD_ASSERT_SAME(a_out_cnt_bound, 1'b1, ocnt_reg <= ewd_pkg::OUT_CNT_W'(ewd_pkg::OUT_DEPTH), "output queue count beyond its depth")

endmodule

// ===== hdl/event_word_deframer_core.sv =====
// Top level of the event word deframer: configuration registers and the
// front part, command queue and back part. Depends on ewd_pkg and all ewd_ modules.
//
// The block takes one word per clock cycle while the command queue is not
// full. A word that closes an event, or the last word of a buffer, places one
// command in a four-entry queue; the back part carries out one command per
// cycle while the output queue has room, but a buffer end that closes an
// event and starts a new chunk writes the event record in BK_RUN and the
// rollover record in BK_ROLL. Records are registered in a four-entry output
// queue, so input words keep flowing while results are not taken, until both
// queues fill. Configuration writes are taken in any cycle and must only be
// made while no item is in flight.
module event_word_deframer_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [31:0] data_word,
    input  logic        buffer_end,
    output logic        empty,
    input  logic        pop,
    output logic        record_kind,
    output logic [1:0]  event_status,
    output logic [11:0] board_number,
    output logic [47:0] event_timestamp,
    output logic [15:0] event_length_bytes,
    output logic [12:0] declared_length_bytes,
    output logic [15:0] record_type,
    output logic [15:0] chunk_number,
    output logic        is_last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [39:0] cfg_data
);

    logic [ewd_pkg::TYPE_BITS-1:0]      type_reg;
    logic [ewd_pkg::MAX_BYTES_BITS-1:0] max_reg;
    logic                               accept;
    logic                               cmd_push;
    ewd_pkg::cmd_t                      cmd_in;
    ewd_pkg::cmd_t                      cmd_head;
    logic                               cmd_empty;
    logic                               cmd_pop;
    ewd_pkg::rec_t                      rec;

    assign cfg_ready = 1'b1;
    assign accept    = push && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            type_reg <= ewd_pkg::TYPE_BITS'(14);
            max_reg  <= ewd_pkg::MAX_BYTES_BITS'(2000000000);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                ewd_pkg::REG_RECORD_TYPE: type_reg <= cfg_data[ewd_pkg::TYPE_BITS-1:0];
                ewd_pkg::REG_MAX_FILE:    max_reg  <= cfg_data;
                default:                  max_reg  <= max_reg;
            endcase
        end
    end

    ewd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .data_word  (data_word),
        .buffer_end (buffer_end),
        .cmd_push   (cmd_push),
        .cmd_data   (cmd_in)
    );

    ewd_cmd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_data (cmd_in),
        .full    (full),
        .rd_en   (cmd_pop),
        .empty   (cmd_empty),
        .head    (cmd_head)
    );

    ewd_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_head       (cmd_head),
        .cmd_empty      (cmd_empty),
        .cmd_pop        (cmd_pop),
        .max_file_bytes (max_reg),
        .pop            (pop),
        .empty          (empty),
        .rec            (rec)
    );

    assign record_kind           = rec.kind;
    assign event_status          = rec.status;
    assign board_number          = rec.board;
    assign event_timestamp       = rec.stamp;
    assign event_length_bytes    = rec.evt_len;
    assign declared_length_bytes = rec.decl;
    assign record_type           = type_reg;
    assign chunk_number          = rec.chunk;
    assign is_last               = rec.last;

endmodule

// ===== tb/event_word_deframer_core_tb.sv =====
// Self-checking testbench for event_word_deframer_core: directed and random word streams,
// with records predicted here and compared field by field. Depends on ewd_pkg and the RTL.
`timescale 1ns / 1ps

module event_word_deframer_core_tb;

    localparam int QUIET_LIMIT   = 3000;
    localparam int SETTLE_CYCLES = 12;

    typedef enum int {
        CLOSE_SEP,
        CLOSE_LAST,
        CLOSE_SEP_BUF,
        CLOSE_SEP_THEN_BUF
    } close_style_t;

    typedef struct packed {
        logic        kind;
        logic [1:0]  status;
        logic [11:0] board;
        logic [47:0] stamp;
        logic [15:0] evt_len;
        logic [12:0] decl;
        logic [15:0] rtype;
        logic [15:0] chunk;
        logic        last;
    } deframe_rec_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [31:0] data_word = '0;
    logic        buffer_end = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic        record_kind;
    logic [1:0]  event_status;
    logic [11:0] board_number;
    logic [47:0] event_timestamp;
    logic [15:0] event_length_bytes;
    logic [12:0] declared_length_bytes;
    logic [15:0] record_type;
    logic [15:0] chunk_number;
    logic        is_last;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = ewd_pkg::REG_RECORD_TYPE;
    logic [39:0] cfg_data = '0;

    // Predicted state of the deframer.
    logic [15:0] type_id = 16'd14;
    logic [39:0] file_limit = 40'd2000000000;
    logic [31:0] header_words [3];
    logic [15:0] evt_bytes = '0;
    logic [40:0] file_bytes = '0;
    logic [15:0] chunk_idx = '0;

    deframe_rec_t expected_recs[$];

    bit idling_on = 1'b1;
    int stall_left = 0;
    int quiet_cycles = 0;
    int mismatches = 0;
    int words_sent = 0;
    int records_seen = 0;
    int n_accepted = 0;
    int n_short = 0;
    int n_mismatched = 0;
    int n_rollovers = 0;

    event_word_deframer_core uut (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .push                  (push),
        .full                  (full),
        .data_word             (data_word),
        .buffer_end            (buffer_end),
        .empty                 (empty),
        .pop                   (pop),
        .record_kind           (record_kind),
        .event_status          (event_status),
        .board_number          (board_number),
        .event_timestamp       (event_timestamp),
        .event_length_bytes    (event_length_bytes),
        .declared_length_bytes (declared_length_bytes),
        .record_type           (record_type),
        .chunk_number          (chunk_number),
        .is_last               (is_last),
        .cfg_valid             (cfg_valid),
        .cfg_ready             (cfg_ready),
        .cfg_index             (cfg_index),
        .cfg_data              (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic logic [31:0] byte_reverse(input logic [31:0] w);
        return {w[7:0], w[15:8], w[23:16], w[31:24]};
    endfunction

    function automatic logic [31:0] make_head0(input logic [11:0] board, input logic [10:0] len_words);
        logic [31:0] sw;
        sw = $urandom;
        sw[26:16] = len_words;
        sw[15:4] = board;
        return byte_reverse(sw);
    endfunction

    task automatic account_word(input logic [31:0] w, input logic at_end);
        deframe_rec_t recs[$];
        deframe_rec_t r;
        logic [31:0] h0;
        logic [31:0] h1;
        logic [31:0] h2;
        logic [15:0] decl16;
        logic [15:0] diff;
        logic [41:0] file_sum;
        if (w != ewd_pkg::SEPARATOR_WORD)
        begin
            if (evt_bytes < 16'd12)
                header_words[evt_bytes[3:2]] = w;
            if (evt_bytes > ewd_pkg::EVT_MAX - 16'd4)
                evt_bytes = ewd_pkg::EVT_MAX;
            else
                evt_bytes = evt_bytes + 16'd4;
        end
        if ((w == ewd_pkg::SEPARATOR_WORD || at_end) && evt_bytes != 0)
        begin
            h0 = byte_reverse(header_words[0]);
            h1 = byte_reverse(header_words[1]);
            h2 = byte_reverse(header_words[2]);
            r = '0;
            r.kind = ewd_pkg::KIND_EVENT;
            r.board = h0[15:4];
            r.decl = {h0[26:16], 2'b00};
            r.stamp = {h2[15:0], h1};
            r.evt_len = evt_bytes;
            r.rtype = type_id;
            r.chunk = chunk_idx;
            decl16 = {3'b000, r.decl};
            diff = (evt_bytes > decl16) ? evt_bytes - decl16 : decl16 - evt_bytes;
            if (evt_bytes < ewd_pkg::MIN_EVENT_BYTES)
            begin
                r.status = ewd_pkg::STAT_SHORT;
                n_short++;
            end
            else if (diff > ewd_pkg::LEN_TOLERANCE)
            begin
                r.status = ewd_pkg::STAT_MISMATCH;
                n_mismatched++;
            end
            else
            begin
                r.status = ewd_pkg::STAT_OK;
                n_accepted++;
                file_sum = 42'(file_bytes) + 42'(ewd_pkg::RECORD_OVERHEAD) + 42'(evt_bytes);
                file_bytes = (file_sum > 42'(ewd_pkg::FILE_MAX)) ? ewd_pkg::FILE_MAX :
                             file_sum[40:0];
            end
            recs = {recs, r};
            evt_bytes = '0;
        end
        if (at_end && 41'(file_bytes) >= 41'(file_limit))
        begin
            chunk_idx = chunk_idx + 16'd1;
            file_bytes = '0;
            r = '0;
            r.kind = ewd_pkg::KIND_ROLL;
            r.rtype = type_id;
            r.chunk = chunk_idx;
            recs = {recs, r};
            n_rollovers++;
        end
        if (recs.size() != 0)
            recs[recs.size() - 1].last = 1'b1;
        expected_recs = {expected_recs, recs};
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $time);
        mismatches++;
    endtask

    task automatic check_field(input string what, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    always @(posedge clk)
    begin : check_results
        deframe_rec_t want;
        if (rst_n && pop && !empty)
        begin
            if (expected_recs.size() == 0)
                report_mismatch("record with nothing expected", 64'(record_kind), 64'(0));
            else
            begin
                want = expected_recs.pop_front();
                records_seen++;
                check_field("record_kind", 64'(record_kind), 64'(want.kind));
                check_field("event_status", 64'(event_status), 64'(want.status));
                check_field("board_number", 64'(board_number), 64'(want.board));
                check_field("event_timestamp", 64'(event_timestamp), 64'(want.stamp));
                check_field("event_length_bytes", 64'(event_length_bytes),
                            64'(want.evt_len));
                check_field("declared_length_bytes", 64'(declared_length_bytes),
                            64'(want.decl));
                check_field("record_type", 64'(record_type), 64'(want.rtype));
                check_field("chunk_number", 64'(chunk_number), 64'(want.chunk));
                check_field("is_last", 64'(is_last), 64'(want.last));
            end
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n || !idling_on)
            pop <= 1'b1;
        else if (stall_left != 0)
        begin
            pop <= 1'b0;
            stall_left = stall_left - 1;
        end
        else if ($urandom_range(0, 9) == 0)
        begin
            pop <= 1'b0;
            stall_left = int'($urandom_range(0, 10));
        end
        else
            pop <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Timed out after %0d cycles with nothing accepted.", QUIET_LIMIT);
            $display("event_word_deframer_core verification failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic send_word(input logic [31:0] w, input logic at_end);
        if (idling_on && $urandom_range(0, 5) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        push <= 1'b1;
        data_word <= w;
        buffer_end <= at_end;
        @(posedge clk);
        while (full)
            @(posedge clk);
        account_word(w, at_end);
        words_sent++;
        @(negedge clk);
    endtask

    task automatic settle_block();
        push <= 1'b0;
        while (expected_recs.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [39:0] value);
        cfg_index <= idx;
        cfg_data <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == ewd_pkg::REG_RECORD_TYPE)
            type_id = value[15:0];
        else
            file_limit = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic send_event(input logic [31:0] w0, input logic [31:0] w1, input logic [31:0] w2,
                              input int nw, input close_style_t how);
        logic [31:0] w;
        for (int i = 0; i < nw; i++)
        begin
            w = (i == 0) ? w0 : (i == 1) ? w1 : (i == 2) ? w2 : $urandom;
            if (w == ewd_pkg::SEPARATOR_WORD)
                w = w ^ 32'h1;
            send_word(w, how == CLOSE_LAST && i == nw - 1);
        end
        if (how != CLOSE_LAST)
            send_word(ewd_pkg::SEPARATOR_WORD, how == CLOSE_SEP_BUF);
        if (how == CLOSE_SEP_THEN_BUF)
            send_word(ewd_pkg::SEPARATOR_WORD, 1'b1);
    endtask

    task automatic send_random_event();
        int pick;
        int nw;
        int lw;
        close_style_t how;
        pick = $urandom_range(0, 99);
        how = close_style_t'($urandom_range(0, 3));
        if (pick >= 90)
        begin
            repeat ($urandom_range(1, 6))
                send_word(($urandom_range(0, 3) == 0) ? ewd_pkg::SEPARATOR_WORD : $urandom,
                          $urandom_range(0, 3) == 0);
        end
        else
        begin
            if (pick < 70)
            begin
                nw = $urandom_range(14, 24);
                lw = nw + $urandom_range(0, 4) - 2;
            end
            else if (pick < 80)
            begin
                nw = $urandom_range(1, 13);
                lw = $urandom_range(0, 2047);
            end
            else
            begin
                nw = $urandom_range(14, 30);
                lw = $urandom_range(0, 2047);
            end
            send_event(make_head0(12'($urandom_range(0, 4095)), 11'(lw)), $urandom, $urandom,
                       nw, how);
        end
    endtask

    task automatic run_random_phase(input logic [15:0] rtype, input logic [39:0] limit,
                                    input int n_words);
        int start;
        settle_block();
        write_reg(ewd_pkg::REG_RECORD_TYPE, 40'(rtype));
        write_reg(ewd_pkg::REG_MAX_FILE, limit);
        start = words_sent;
        while (words_sent - start < n_words)
            send_random_event();
    endtask

    // Every header entry is written by this first full event before any short one reads it.
    task automatic test_first_events();
        send_event(make_head0(12'hfff, 11'd14), 32'hffffffff, 32'hffffffff, 14, CLOSE_SEP);
        send_word(ewd_pkg::SEPARATOR_WORD, 1'b0);
        send_word(ewd_pkg::SEPARATOR_WORD, 1'b0);
    endtask

    task automatic test_length_limits();
        send_event(make_head0(12'h000, 11'd16), 32'h0, 32'h0, 14, CLOSE_LAST);
        send_event(make_head0(12'h5a5, 11'd14), $urandom, $urandom, 16, CLOSE_SEP_BUF);
        send_event(make_head0(12'h3c3, 11'd17), $urandom, $urandom, 14, CLOSE_SEP);
        send_event(make_head0(12'hfff, 11'h7ff), $urandom, $urandom, 14, CLOSE_SEP);
    endtask

    task automatic test_short_events();
        send_event(make_head0(12'h123, 11'd1), $urandom, $urandom, 1, CLOSE_SEP);
        send_event(make_head0(12'h456, 11'd2), $urandom, $urandom, 2, CLOSE_LAST);
        send_event(make_head0(12'h789, 11'd13), $urandom, $urandom, 13, CLOSE_SEP);
    endtask

    task automatic test_buffer_end_alone();
        send_word(ewd_pkg::SEPARATOR_WORD, 1'b1);
        send_word(ewd_pkg::SEPARATOR_WORD, 1'b1);
    endtask

    task automatic test_registers();
        settle_block();
        write_reg(ewd_pkg::REG_RECORD_TYPE, 40'd0);
        write_reg(ewd_pkg::REG_MAX_FILE, 40'd1);
        send_event(make_head0(12'h0f0, 11'd15), $urandom, $urandom, 15, CLOSE_LAST);
        send_word(ewd_pkg::SEPARATOR_WORD, 1'b1);
        settle_block();
        write_reg(ewd_pkg::REG_RECORD_TYPE, 40'hffff);
        write_reg(ewd_pkg::REG_MAX_FILE, 40'hff_ffff_ffff);
        send_event(make_head0(12'h00f, 11'd14), $urandom, $urandom, 14, CLOSE_SEP_BUF);
        settle_block();
        write_reg(ewd_pkg::REG_MAX_FILE, 40'd0);
        send_word(ewd_pkg::SEPARATOR_WORD, 1'b1);
        send_event(make_head0(12'haaa, 11'd14), $urandom, $urandom, 14, CLOSE_SEP_THEN_BUF);
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: run_random_phase(16'($urandom), 40'($urandom_range(200, 800)), 80);
                1: run_random_phase(16'h0000, 40'd1, 80);
                2: run_random_phase(16'hffff, 40'hff_ffff_ffff, 80);
                3: run_random_phase(16'($urandom), 40'({$urandom, $urandom}), 80);
                default: run_random_phase(16'($urandom), 40'($urandom_range(60, 400)), 80);
            endcase
        end
    endtask

    task automatic test_chunk_rollover();
        settle_block();
        write_reg(ewd_pkg::REG_RECORD_TYPE, 40'($urandom));
        write_reg(ewd_pkg::REG_MAX_FILE, 40'd0);
        repeat (20)
            send_word(ewd_pkg::SEPARATOR_WORD, 1'b1);
    endtask

    initial
    begin
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        test_first_events();
        test_length_limits();
        test_short_events();
        test_buffer_end_alone();
        test_registers();
        test_random_traffic();

        idling_on = 1'b0;
        run_random_phase(16'($urandom), 40'($urandom_range(100, 600)), 70);
        test_chunk_rollover();

        settle_block();
        repeat (20) @(negedge clk);
        $display("Sent %0d words; checked %0d records: %0d accepted, %0d too short,",
                 words_sent, records_seen, n_accepted, n_short);
        $display("%0d length mismatches and %0d chunk rollovers.", n_mismatched, n_rollovers);
        if (mismatches == 0)
            $display("event_word_deframer_core verification clean");
        else
            $display("event_word_deframer_core verification failed");
        $finish;
    end

endmodule
